/* sv/descent_deployment_sequencer_top_defines.svh */
// Assertion macros used by the checker of the descent sequencer.
`ifndef DESCENT_DEPLOYMENT_SEQUENCER_TOP_DEFINES_SVH
`define DESCENT_DEPLOYMENT_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define DDSEQ_ASSERT_NOW(label, ant, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |-> (cons)) \
        else $error("descent sequencer check failed");

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define DDSEQ_ASSERT_NEXT(label, ant, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |=> (cons)) \
        else $error("descent sequencer check failed");

`endif

/* sv/ddseq_pkg.sv */
// Types, codes and helpers of the descent deployment sequencer.
`timescale 1ns / 1ps

package ddseq_pkg;

    localparam int ALT_BITS_DEFAULT = 24;

    localparam int CMD_W     = 2;
    localparam int FORCE_W   = 4;
    localparam int PHASE_W   = 4;
    localparam int MARGIN_W  = 16;
    localparam int CONFIRM_W = 8;
    localparam int FRAC_W    = 16;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PASS   = 2'd0,
        CMD_SAMPLE = 2'd1,
        CMD_FORCE  = 2'd2,
        CMD_SPARE  = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MARGIN    = 2'd0,
        CFG_CONFIRM   = 2'd1,
        CFG_FRACTION  = 2'd2,
        CFG_PROBE_ALT = 2'd3
    } cfg_idx_t;

    localparam logic [PHASE_W-1:0] PH_DISARMED  = 4'd0;
    localparam logic [PHASE_W-1:0] PH_ARMED     = 4'd1;
    localparam logic [PHASE_W-1:0] PH_ASCENT    = 4'd2;
    localparam logic [PHASE_W-1:0] PH_APOGEE    = 4'd3;
    localparam logic [PHASE_W-1:0] PH_PREPAY    = 4'd4;
    localparam logic [PHASE_W-1:0] PH_PAY       = 4'd5;
    localparam logic [PHASE_W-1:0] PH_PREPROBE  = 4'd6;
    localparam logic [PHASE_W-1:0] PH_PROBE     = 4'd7;
    localparam logic [PHASE_W-1:0] PH_POSTPROBE = 4'd8;
    localparam logic [PHASE_W-1:0] PH_GROUNDED  = 4'd9;
    localparam logic [PHASE_W-1:0] PH_FAULT     = 4'd10;

    localparam logic [MARGIN_W-1:0]  MARGIN_RESET    = 16'd100;
    localparam logic [CONFIRM_W-1:0] CONFIRM_RESET   = 8'd3;
    localparam logic [FRAC_W-1:0]    FRAC_RESET      = 16'd49152;
    localparam int                   PROBE_ALT_RESET = 30000;

    // result word layout, low fields fixed, apogee above them
    localparam int OUT_PHASE_LSB  = 0;
    localparam int OUT_CHANGED    = 4;
    localparam int OUT_FIRE_PAY   = 5;
    localparam int OUT_FIRE_PROBE = 6;
    localparam int OUT_CAMERAS    = 7;
    localparam int OUT_APOGEE_LSB = 8;

    typedef enum logic [10:0] {
        S_DISARMED  = 11'b000_0000_0001,
        S_ARMED     = 11'b000_0000_0010,
        S_ASCENT    = 11'b000_0000_0100,
        S_APOGEE    = 11'b000_0000_1000,
        S_PREPAY    = 11'b000_0001_0000,
        S_PAY       = 11'b000_0010_0000,
        S_PREPROBE  = 11'b000_0100_0000,
        S_PROBE     = 11'b000_1000_0000,
        S_POSTPROBE = 11'b001_0000_0000,
        S_GROUNDED  = 11'b010_0000_0000,
        S_FAULT     = 11'b100_0000_0000
    } phase_t;

    function automatic logic [PHASE_W-1:0] phase_code(phase_t p);
        logic [PHASE_W-1:0] c;
        unique case (p)
            S_DISARMED:  c = PH_DISARMED;
            S_ARMED:     c = PH_ARMED;
            S_ASCENT:    c = PH_ASCENT;
            S_APOGEE:    c = PH_APOGEE;
            S_PREPAY:    c = PH_PREPAY;
            S_PAY:       c = PH_PAY;
            S_PREPROBE:  c = PH_PREPROBE;
            S_PROBE:     c = PH_PROBE;
            S_POSTPROBE: c = PH_POSTPROBE;
            S_GROUNDED:  c = PH_GROUNDED;
            default:     c = PH_FAULT;
        endcase
        return c;
    endfunction

    // codes above fault land in fault
    function automatic phase_t phase_decode(logic [PHASE_W-1:0] c);
        phase_t p;
        unique case (c)
            PH_DISARMED:  p = S_DISARMED;
            PH_ARMED:     p = S_ARMED;
            PH_ASCENT:    p = S_ASCENT;
            PH_APOGEE:    p = S_APOGEE;
            PH_PREPAY:    p = S_PREPAY;
            PH_PAY:       p = S_PAY;
            PH_PREPROBE:  p = S_PREPROBE;
            PH_PROBE:     p = S_PROBE;
            PH_POSTPROBE: p = S_POSTPROBE;
            PH_GROUNDED:  p = S_GROUNDED;
            default:      p = S_FAULT;
        endcase
        return p;
    endfunction

endpackage

/* sv/descent_deployment_sequencer_top.sv */
// Descent deployment sequencer: flight phase state machine with release pulses.
`timescale 1ns / 1ps

// One request is one pass of the flight control loop (tuser: 0 pass, 1 pass with
// a new altitude sample, 2 forced phase write, 3 same as 0); every request gives
// exactly one result with the phase after the pass, the phase-changed flag, the
// payload, probe and camera pulses and the current apogee. A request is held in
// the input register and is resolved into the result register when the result
// side can take it, so a new request is taken every cycle while the result side
// keeps up. The rate is set by the update of the phase and apogee registers,
// which every pass reads back. The payload threshold (fraction times apogee)
// comes from a registered multiplier fed from the apogee and fraction registers.
// Requests are held off in a cycle that carries a configuration write and in
// the first cycle after reset.
module descent_deployment_sequencer_top
    import ddseq_pkg::*;
#(
    parameter int ALT_BITS = ALT_BITS_DEFAULT,
    localparam int S_DATA_W = ((ALT_BITS + 6 + 7) / 8) * 8,
    localparam int M_DATA_W = ((ALT_BITS + 8 + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    // altitude_cm, launch_seen, on_ground, forced_state[3:0], zero fill
    input  logic [S_DATA_W-1:0]  s_tdata,
    // cmd[1:0]
    input  logic [CMD_W-1:0]     s_tuser,

    output logic                 m_tvalid,
    input  logic                 m_tready,
    // phase[3:0], phase_changed, fire_payload, fire_probe, start_cameras,
    // apogee_cm, zero fill
    output logic [M_DATA_W-1:0]  m_tdata,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ALT_BITS-1:0]  cfg_data
);

    localparam int PROD_W = ALT_BITS + FRAC_W + 1;
    localparam int CMP_W  = ALT_BITS + 2;

    // configuration
    logic [MARGIN_W-1:0]         margin_reg;
    logic [CONFIRM_W-1:0]        confirm_reg;
    logic [FRAC_W-1:0]           frac_reg;
    logic signed [ALT_BITS-1:0]  probe_alt_reg;

    // handshake
    logic ready_en_reg;
    logic in_valid_reg;
    logic out_valid_reg;
    logic advance;
    logic s_accept;
    logic do_step;

    // input register
    cmd_t                        in_cmd_reg;
    logic signed [ALT_BITS-1:0]  in_alt_reg;
    logic                        in_launch_reg;
    logic                        in_ground_reg;
    logic [FORCE_W-1:0]          in_forced_reg;

    // flight state
    phase_t                      phase_reg, phase_next;
    logic signed [ALT_BITS-1:0]  apogee_reg, apogee_next;
    logic signed [ALT_BITS-1:0]  last_alt_reg, last_alt_next;
    logic [CONFIRM_W-1:0]        count_reg, count_next;
    logic                        pay_done_reg, pay_done_next;
    logic                        probe_done_reg, probe_done_next;
    logic                        ground_reg, ground_next;
    logic signed [PROD_W-1:0]    prod_reg;

    // result register
    logic [PHASE_W-1:0]          out_phase_reg;
    logic                        out_changed_reg;
    logic                        out_pay_reg;
    logic                        out_probe_reg;
    logic                        out_cam_reg;
    logic signed [ALT_BITS-1:0]  out_apogee_reg;

    logic                        fire_pay, fire_probe, cams;
    logic signed [CMP_W-1:0]     margin_floor;
    logic signed [CMP_W-1:0]     alt_wide;
    logic signed [PROD_W-1:0]    alt_scaled;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = ready_en_reg && !cfg_we && (!in_valid_reg || advance);
    assign s_accept = s_tvalid && s_tready;
    assign do_step  = in_valid_reg && advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            margin_reg    <= MARGIN_RESET;
            confirm_reg   <= CONFIRM_RESET;
            frac_reg      <= FRAC_RESET;
            probe_alt_reg <= ALT_BITS'(PROBE_ALT_RESET);
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MARGIN:    margin_reg    <= cfg_data[MARGIN_W-1:0];
                CFG_CONFIRM:   confirm_reg   <= cfg_data[CONFIRM_W-1:0];
                CFG_FRACTION:  frac_reg      <= cfg_data[FRAC_W-1:0];
                CFG_PROBE_ALT: probe_alt_reg <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    // threshold is registered from apogee and fraction
    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'($signed({1'b0, frac_reg})) * PROD_W'(apogee_reg);
    end

    always_comb begin
        margin_floor = CMP_W'(apogee_reg) - $signed({{(CMP_W - MARGIN_W){1'b0}}, margin_reg});
        alt_wide     = CMP_W'(in_alt_reg);

        phase_next      = phase_reg;
        apogee_next     = apogee_reg;
        last_alt_next   = last_alt_reg;
        count_next      = count_reg;
        pay_done_next   = pay_done_reg;
        probe_done_next = probe_done_reg;
        ground_next     = ground_reg;
        fire_pay        = 1'b0;
        fire_probe      = 1'b0;
        cams            = 1'b0;
        alt_scaled      = '0;

        if (in_cmd_reg == CMD_FORCE) begin
            phase_next = phase_decode(in_forced_reg);
        end else begin
            if (in_cmd_reg == CMD_SAMPLE) begin
                ground_next   = in_ground_reg;
                last_alt_next = in_alt_reg;
                if (phase_reg == S_ASCENT) begin
                    if (in_alt_reg > apogee_reg) begin
                        apogee_next = in_alt_reg;
                        count_next  = '0;
                    end else if (alt_wide < margin_floor) begin
                        if (count_reg != {CONFIRM_W{1'b1}}) begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
            end
            alt_scaled = $signed({last_alt_next[ALT_BITS-1], last_alt_next, {FRAC_W{1'b0}}});
            unique case (phase_reg) inside
                S_DISARMED: ;
                S_ARMED: begin
                    if (in_launch_reg) begin
                        cams       = 1'b1;
                        phase_next = S_ASCENT;
                    end
                end
                S_ASCENT: begin
                    if (count_next >= confirm_reg) begin
                        phase_next = S_APOGEE;
                    end
                end
                S_APOGEE: phase_next = S_PREPAY;
                S_PREPAY: begin
                    if (ground_next) begin
                        phase_next = S_GROUNDED;
                    end else if (apogee_reg > 0 && !pay_done_reg &&
                                 alt_scaled <= prod_reg) begin
                        phase_next = S_PAY;
                    end
                end
                S_PAY: begin
                    if (!pay_done_reg) begin
                        fire_pay      = 1'b1;
                        pay_done_next = 1'b1;
                    end
                    phase_next = S_PREPROBE;
                end
                S_PREPROBE: begin
                    if (ground_next) begin
                        phase_next = S_GROUNDED;
                    end else if (last_alt_next <= probe_alt_reg) begin
                        phase_next = S_PROBE;
                    end
                end
                S_PROBE: begin
                    if (!probe_done_reg) begin
                        fire_probe      = 1'b1;
                        probe_done_next = 1'b1;
                    end
                    phase_next = S_POSTPROBE;
                end
                S_POSTPROBE: begin
                    if (ground_next) begin
                        phase_next = S_GROUNDED;
                    end
                end
                S_GROUNDED, S_FAULT: ;
                default: phase_next = S_FAULT;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ready_en_reg   <= 1'b0;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            phase_reg      <= S_DISARMED;
            apogee_reg     <= '0;
            last_alt_reg   <= '0;
            count_reg      <= '0;
            pay_done_reg   <= 1'b0;
            probe_done_reg <= 1'b0;
            ground_reg     <= 1'b0;
        end else begin
            ready_en_reg <= 1'b1;
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (do_step) begin
                phase_reg      <= phase_next;
                apogee_reg     <= apogee_next;
                last_alt_reg   <= last_alt_next;
                count_reg      <= count_next;
                pay_done_reg   <= pay_done_next;
                probe_done_reg <= probe_done_next;
                ground_reg     <= ground_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_cmd_reg    <= cmd_t'(s_tuser);
            in_alt_reg    <= $signed(s_tdata[ALT_BITS-1:0]);
            in_launch_reg <= s_tdata[ALT_BITS];
            in_ground_reg <= s_tdata[ALT_BITS+1];
            in_forced_reg <= s_tdata[ALT_BITS+2 +: FORCE_W];
        end
        if (do_step) begin
            out_phase_reg   <= phase_code(phase_next);
            out_changed_reg <= (phase_next != phase_reg);
            out_pay_reg     <= fire_pay;
            out_probe_reg   <= fire_probe;
            out_cam_reg     <= cams;
            out_apogee_reg  <= apogee_next;
        end
    end

    assign m_tvalid = out_valid_reg;

    always_comb begin
        m_tdata = '0;
        m_tdata[OUT_PHASE_LSB +: PHASE_W]   = out_phase_reg;
        m_tdata[OUT_CHANGED]                = out_changed_reg;
        m_tdata[OUT_FIRE_PAY]               = out_pay_reg;
        m_tdata[OUT_FIRE_PROBE]             = out_probe_reg;
        m_tdata[OUT_CAMERAS]                = out_cam_reg;
        m_tdata[OUT_APOGEE_LSB +: ALT_BITS] = out_apogee_reg;
    end

endmodule

/* sv/ddseq_checker.sv */
// Port-level checker for the descent deployment sequencer, with its bind.
`timescale 1ns / 1ps
`include "descent_deployment_sequencer_top_defines.svh"

module ddseq_checker
    import ddseq_pkg::*;
#(
    parameter int ALT_BITS = ALT_BITS_DEFAULT,
    localparam int M_DATA_W = ((ALT_BITS + 8 + 7) / 8) * 8
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_DATA_W-1:0]  m_tdata,
    input logic                 cfg_we
);

    logic [PHASE_W-1:0] phase_out;
    assign phase_out = m_tdata[OUT_PHASE_LSB +: PHASE_W];

    // stalled result holds
    `DDSEQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // a payload pulse comes with the step into pre-probe
    `DDSEQ_ASSERT_NOW(a_pay_phase, m_tvalid && m_tdata[OUT_FIRE_PAY],
        phase_out == PH_PREPROBE && m_tdata[OUT_CHANGED])

    // a probe pulse comes with the step into post-probe
    `DDSEQ_ASSERT_NOW(a_probe_phase, m_tvalid && m_tdata[OUT_FIRE_PROBE],
        phase_out == PH_POSTPROBE && m_tdata[OUT_CHANGED])

    // cameras start only on entry to ascent
    `DDSEQ_ASSERT_NOW(a_cam_phase, m_tvalid && m_tdata[OUT_CAMERAS],
        phase_out == PH_ASCENT && m_tdata[OUT_CHANGED])

    // no request is taken during a configuration write
    `DDSEQ_ASSERT_NOW(a_cfg_block, cfg_we, !s_tready)

endmodule

bind descent_deployment_sequencer_top ddseq_checker #(
    .ALT_BITS(ALT_BITS)
) u_ddseq_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we)
);

/* sim/descent_deployment_sequencer_top_test.sv */
// Self-checking testbench of the descent deployment sequencer, with a built-in phase predictor.
`timescale 1ns / 1ps

module descent_deployment_sequencer_top_test;
    import ddseq_pkg::*;

    localparam int ALT_W       = 24;
    localparam int S_W         = ((ALT_W + 6 + 7) / 8) * 8;
    localparam int M_W         = ((ALT_W + 8 + 7) / 8) * 8;
    localparam int PHASE_ITEMS = 220;
    localparam int NUM_PHASES  = 7;
    localparam int RX_HOLD     = 400;
    localparam int STALL_LIMIT = 4000;

    typedef struct {
        cmd_t                    cmd;
        logic signed [ALT_W-1:0] alt;
        logic                    launch;
        logic                    ground;
        logic [FORCE_W-1:0]      forced;
    } pass_req_t;

    typedef struct {
        logic [PHASE_W-1:0]      phase;
        logic                    changed, fire_pay, fire_probe, cameras;
        logic signed [ALT_W-1:0] apogee;
    } pass_report_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_W-1:0]       s_tdata = '0;
    logic [CMD_W-1:0]     s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_W-1:0]       m_tdata;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ALT_W-1:0]     cfg_data = '0;

    descent_deployment_sequencer_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // predicted sequencer state and configuration
    logic [MARGIN_W-1:0]     cfg_margin  = MARGIN_RESET;
    logic [CONFIRM_W-1:0]    cfg_confirm = CONFIRM_RESET;
    logic [FRAC_W-1:0]       cfg_frac    = FRAC_RESET;
    logic signed [ALT_W-1:0] cfg_probe   = ALT_W'(PROBE_ALT_RESET);
    logic [PHASE_W-1:0]      cur_phase   = PH_DISARMED;
    logic signed [ALT_W-1:0] apogee      = '0;
    logic signed [ALT_W-1:0] last_alt    = '0;
    logic [7:0]              descents    = '0;
    logic                    payload_done = 1'b0;
    logic                    probe_done   = 1'b0;
    logic                    gnd_latch    = 1'b0;

    pass_req_t    request_queue[$];
    pass_report_t phase_reports_due[$];
    pass_req_t    cur_req;
    bit           in_fire, out_fire;
    int           mismatches = 0;
    int           stall_cycles = 0;
    int           gap_left = 0, burst_left = 0;
    int           rx_cycle = 0, rx_mode = 0, hold_left = 0, next_hold = 900;
    longint       gen_peak;

    function automatic pass_report_t advance_flight(pass_req_t rq);
        pass_report_t r;
        logic [PHASE_W-1:0] prev, nxt;
        longint lhs, rhs;
        prev = cur_phase;
        nxt = cur_phase;
        r.fire_pay = 1'b0;
        r.fire_probe = 1'b0;
        r.cameras = 1'b0;
        if (rq.cmd == CMD_FORCE) begin
            nxt = (rq.forced > PH_FAULT) ? PH_FAULT : rq.forced;
        end else begin
            if (rq.cmd == CMD_SAMPLE) begin
                gnd_latch = rq.ground;
                last_alt = rq.alt;
                if (cur_phase == PH_ASCENT) begin
                    if (rq.alt > apogee) begin
                        apogee = rq.alt;
                        descents = '0;
                    end else if (longint'(rq.alt) < longint'(apogee) - longint'(cfg_margin)) begin
                        if (descents != 8'hFF) descents = descents + 1'b1;
                    end
                end
            end
            case (cur_phase) inside
                PH_DISARMED, PH_GROUNDED, PH_FAULT: begin
                end
                PH_ARMED: begin
                    if (rq.launch) begin
                        r.cameras = 1'b1;
                        nxt = PH_ASCENT;
                    end
                end
                PH_ASCENT: begin
                    if (descents >= cfg_confirm) nxt = PH_APOGEE;
                end
                PH_APOGEE: nxt = PH_PREPAY;
                PH_PREPAY: begin
                    lhs = longint'(last_alt) * 65536;
                    rhs = longint'(cfg_frac) * longint'(apogee);
                    if (gnd_latch) nxt = PH_GROUNDED;
                    else if (apogee > 0 && !payload_done && lhs <= rhs) nxt = PH_PAY;
                end
                PH_PAY: begin
                    if (!payload_done) begin
                        r.fire_pay = 1'b1;
                        payload_done = 1'b1;
                    end
                    nxt = PH_PREPROBE;
                end
                PH_PREPROBE: begin
                    if (gnd_latch) nxt = PH_GROUNDED;
                    else if (last_alt <= cfg_probe) nxt = PH_PROBE;
                end
                PH_PROBE: begin
                    if (!probe_done) begin
                        r.fire_probe = 1'b1;
                        probe_done = 1'b1;
                    end
                    nxt = PH_POSTPROBE;
                end
                PH_POSTPROBE: begin
                    if (gnd_latch) nxt = PH_GROUNDED;
                end
                default: nxt = PH_FAULT;
            endcase
        end
        cur_phase = nxt;
        r.phase = nxt;
        r.changed = (nxt != prev);
        r.apogee = apogee;
        return r;
    endfunction

    function automatic logic [ALT_W-1:0] to_alt(longint v);
        if (v > 64'sd8388607) return 24'h7FFFFF;
        if (v < -64'sd8388608) return 24'h800000;
        return v[ALT_W-1:0];
    endfunction

    task automatic add_req(cmd_t cmd, logic [ALT_W-1:0] alt, logic launch, logic ground,
                           logic [FORCE_W-1:0] forced);
        pass_req_t rq;
        rq.cmd = cmd;
        rq.alt = alt;
        rq.launch = launch;
        rq.ground = ground;
        rq.forced = forced;
        request_queue.push_back(rq);
    endtask

    task automatic add_noise();
        repeat ($urandom_range(3, 12))
            add_req(cmd_t'($urandom_range(0, 3)), ALT_W'($urandom), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), FORCE_W'($urandom_range(0, 15)));
    endtask

    // one well-formed flight from the pad to the ground, random content
    task automatic add_flight();
        longint peak, floor_alt, v;
        int n_up, n_down, n_fall;
        bit early_ground;
        add_req(CMD_FORCE, ALT_W'($urandom), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), PH_DISARMED);
        repeat ($urandom_range(0, 2))
            add_req($urandom_range(0, 1) ? CMD_PASS : CMD_SPARE, ALT_W'($urandom),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    FORCE_W'($urandom_range(0, 15)));
        add_req(CMD_FORCE, ALT_W'($urandom), 1'b0, 1'b0,
                ($urandom_range(0, 9) == 0) ? PH_ASCENT : PH_ARMED);
        repeat ($urandom_range(0, 3))
            add_req(CMD_SAMPLE, ALT_W'($urandom_range(0, 500)), 1'b0, 1'b0,
                    FORCE_W'($urandom_range(0, 15)));
        add_req($urandom_range(0, 1) ? CMD_PASS : CMD_SAMPLE, ALT_W'($urandom_range(0, 500)),
                1'b1, 1'b0, FORCE_W'($urandom_range(0, 15)));

        if ($urandom_range(0, 6) == 0) peak = longint'($urandom_range(300000, 8388607));
        else peak = longint'($urandom_range(2000, 300000));
        n_up = $urandom_range(2, 8);
        for (int i = 0; i < n_up; i++) begin
            add_req(CMD_SAMPLE, to_alt(peak * (i + 1) / n_up), 1'($urandom_range(0, 1)), 1'b0,
                    FORCE_W'($urandom_range(0, 15)));
            if ($urandom_range(0, 3) == 0)
                add_req(CMD_PASS, ALT_W'($urandom), 1'($urandom_range(0, 1)), 1'b0,
                        FORCE_W'($urandom_range(0, 15)));
        end
        if (peak > gen_peak) gen_peak = peak;

        n_down = int'(cfg_confirm) + $urandom_range(0, 2);
        for (int i = 0; i < n_down; i++) begin
            v = gen_peak - longint'(cfg_margin) - 1 - longint'($urandom_range(0, 2000));
            add_req(CMD_SAMPLE, to_alt(v), 1'($urandom_range(0, 1)), 1'b0,
                    FORCE_W'($urandom_range(0, 15)));
            if ($urandom_range(0, 5) == 0)
                add_req(CMD_PASS, ALT_W'($urandom), 1'($urandom_range(0, 1)), 1'b0,
                        FORCE_W'($urandom_range(0, 15)));
        end

        floor_alt = ((cfg_probe < 0) ? longint'(cfg_probe) : 64'sd0)
                    - longint'($urandom_range(0, 1000));
        n_fall = $urandom_range(3, 10);
        early_ground = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < n_fall; i++) begin
            v = gen_peak - (gen_peak - floor_alt) * (i + 1) / n_fall;
            add_req(CMD_SAMPLE, to_alt(v), 1'($urandom_range(0, 1)),
                    early_ground && i == n_fall / 2, FORCE_W'($urandom_range(0, 15)));
            if ($urandom_range(0, 1) == 0)
                add_req(CMD_PASS, ALT_W'($urandom), 1'($urandom_range(0, 1)), 1'b0,
                        FORCE_W'($urandom_range(0, 15)));
        end
        add_req(CMD_SAMPLE, to_alt(floor_alt), 1'b0, 1'b1, FORCE_W'($urandom_range(0, 15)));
        repeat ($urandom_range(0, 2))
            add_req(CMD_PASS, ALT_W'($urandom), 1'($urandom_range(0, 1)), 1'b0,
                    FORCE_W'($urandom_range(0, 15)));
        if ($urandom_range(0, 9) == 0)
            add_req(CMD_FORCE, ALT_W'($urandom), 1'b0, 1'b0, FORCE_W'($urandom_range(0, 15)));
    endtask

    task automatic cfg_write(cfg_idx_t idx, logic [ALT_W-1:0] value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (request_queue.size() != 0 || s_tvalid || phase_reports_due.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // request driver: bursts with random gaps
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || in_fire)) begin
            if (gap_left != 0) begin
                gap_left = gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (request_queue.size() != 0) begin
                cur_req = request_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {{(S_W - ALT_W - 6){1'b0}}, cur_req.forced, cur_req.ground,
                            cur_req.launch, cur_req.alt};
                s_tuser <= cur_req.cmd;
                if (burst_left > 1) begin
                    burst_left = burst_left - 1;
                end else if ($urandom_range(0, 3) == 0) begin
                    burst_left = $urandom_range(20, 60);
                    gap_left = 0;
                end else begin
                    burst_left = $urandom_range(1, 16);
                    gap_left = $urandom_range(1, 8);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver: stall pattern plus an occasional long hold-off under load
    always @(negedge aclk) begin
        rx_cycle = rx_cycle + 1;
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (rx_cycle >= next_hold && s_tvalid) begin
            hold_left = RX_HOLD;
            next_hold = rx_cycle + 2600;
            m_tready <= 1'b0;
        end else begin
            if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= (rx_cycle[1:0] == 2'b00);
                default: m_tready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // monitor: predict on accepted requests, check accepted results
    always @(posedge aclk) begin
        pass_report_t exp_r, got_r;
        in_fire = aresetn && s_tvalid && s_tready;
        out_fire = aresetn && m_tvalid && m_tready;
        if (aresetn && cfg_we) begin
            case (cfg_index)
                CFG_MARGIN:    cfg_margin = cfg_data[MARGIN_W-1:0];
                CFG_CONFIRM:   cfg_confirm = cfg_data[CONFIRM_W-1:0];
                CFG_FRACTION:  cfg_frac = cfg_data[FRAC_W-1:0];
                CFG_PROBE_ALT: cfg_probe = cfg_data;
                default: begin
                end
            endcase
        end
        if (in_fire) phase_reports_due.push_back(advance_flight(cur_req));
        if (out_fire) begin
            got_r.phase = m_tdata[OUT_PHASE_LSB +: PHASE_W];
            got_r.changed = m_tdata[OUT_CHANGED];
            got_r.fire_pay = m_tdata[OUT_FIRE_PAY];
            got_r.fire_probe = m_tdata[OUT_FIRE_PROBE];
            got_r.cameras = m_tdata[OUT_CAMERAS];
            got_r.apogee = m_tdata[OUT_APOGEE_LSB +: ALT_W];
            if (phase_reports_due.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("result with no request pending: phase %0d apogee %0d",
                             got_r.phase, got_r.apogee);
            end else begin
                exp_r = phase_reports_due.pop_front();
                if ({exp_r.phase, exp_r.changed, exp_r.fire_pay, exp_r.fire_probe,
                     exp_r.cameras, exp_r.apogee} !==
                    {got_r.phase, got_r.changed, got_r.fire_pay, got_r.fire_probe,
                     got_r.cameras, got_r.apogee}) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("result mismatch: expected phase %0d chg %0b pay %0b ",
                                 exp_r.phase, exp_r.changed, exp_r.fire_pay,
                                 "prb %0b cam %0b apogee %0d; ", exp_r.fire_probe,
                                 exp_r.cameras, exp_r.apogee,
                                 "got phase %0d chg %0b pay %0b ", got_r.phase,
                                 got_r.changed, got_r.fire_pay,
                                 "prb %0b cam %0b apogee %0d", got_r.fire_probe,
                                 got_r.cameras, got_r.apogee);
                end
            end
        end
        if (in_fire || out_fire || cfg_we) begin
            stall_cycles = 0;
        end else begin
            stall_cycles = stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        logic [MARGIN_W-1:0]  margin_v;
        logic [CONFIRM_W-1:0] confirm_v;
        logic [FRAC_W-1:0]    frac_v;
        logic [ALT_W-1:0]     probe_v;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed flight at reset settings
        add_req(CMD_PASS,   24'd0,      1'b1, 1'b0, 4'd0);
        add_req(CMD_SPARE,  24'h7FFFFF, 1'b1, 1'b1, 4'hF);
        add_req(CMD_SAMPLE, 24'h800000, 1'b0, 1'b0, 4'd0);
        add_req(CMD_FORCE,  24'd0,      1'b0, 1'b0, PH_ARMED);
        add_req(CMD_SAMPLE, 24'd0,      1'b0, 1'b0, 4'd0);
        add_req(CMD_PASS,   24'd0,      1'b1, 1'b0, 4'd0);
        add_req(CMD_SAMPLE, 24'd20000,  1'b0, 1'b0, 4'd0);
        add_req(CMD_SAMPLE, 24'd50000,  1'b0, 1'b0, 4'd0);
        // inside the margin, then just past it
        add_req(CMD_SAMPLE, 24'd49950,  1'b0, 1'b0, 4'd0);
        add_req(CMD_SAMPLE, 24'd49899,  1'b0, 1'b0, 4'd0);
        add_req(CMD_PASS,   24'd0,      1'b0, 1'b0, 4'd0);
        add_req(CMD_SAMPLE, 24'd40000,  1'b0, 1'b0, 4'd0);
        add_req(CMD_SAMPLE, 24'd30000,  1'b0, 1'b0, 4'd0);
        add_req(CMD_PASS,   24'd0,      1'b0, 1'b0, 4'd0);
        // one above the release threshold, then exactly on it
        add_req(CMD_SAMPLE, 24'd37501,  1'b0, 1'b0, 4'd0);
        add_req(CMD_SAMPLE, 24'd37500,  1'b0, 1'b0, 4'd0);
        add_req(CMD_PASS,   24'd0,      1'b0, 1'b0, 4'd0);
        add_req(CMD_SAMPLE, 24'd30001,  1'b0, 1'b0, 4'd0);
        add_req(CMD_SAMPLE, 24'd30000,  1'b0, 1'b0, 4'd0);
        add_req(CMD_PASS,   24'd0,      1'b0, 1'b0, 4'd0);
        add_req(CMD_SAMPLE, 24'd0,      1'b0, 1'b1, 4'd0);
        // re-enter release phases with the sticky flags set
        add_req(CMD_FORCE,  24'd0,      1'b0, 1'b0, PH_PAY);
        add_req(CMD_PASS,   24'd0,      1'b0, 1'b0, 4'd0);
        add_req(CMD_FORCE,  24'd0,      1'b0, 1'b0, 4'd15);
        add_req(CMD_FORCE,  24'd0,      1'b0, 1'b0, 4'd11);
        add_req(CMD_FORCE,  24'd0,      1'b0, 1'b0, PH_PROBE);
        add_req(CMD_PASS,   24'd0,      1'b0, 1'b0, 4'd0);
        add_req(CMD_PASS,   24'd0,      1'b0, 1'b0, 4'd0);
        add_req(CMD_FORCE,  24'd0,      1'b0, 1'b0, PH_DISARMED);
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin
                    margin_v = '0;
                    confirm_v = 8'd1;
                    frac_v = 16'hFFFF;
                    probe_v = 24'h7FFFFF;
                end
                1: begin
                    margin_v = 16'hFFFF;
                    confirm_v = 8'd255;
                    frac_v = '0;
                    probe_v = 24'h800000;
                end
                2: begin
                    // zero confirm count leaves ascent on the next pass
                    margin_v = 16'd100;
                    confirm_v = '0;
                    frac_v = 16'h8000;
                    probe_v = '0;
                end
                default: begin
                    margin_v = MARGIN_W'($urandom_range(0, 3000));
                    confirm_v = CONFIRM_W'($urandom_range(1, 10));
                    frac_v = FRAC_W'($urandom);
                    probe_v = to_alt(longint'($urandom_range(0, 400000)) - 100000);
                end
            endcase
            cfg_write(CFG_MARGIN, {8'd0, margin_v});
            cfg_write(CFG_CONFIRM, {16'd0, confirm_v});
            cfg_write(CFG_FRACTION, {8'd0, frac_v});
            cfg_write(CFG_PROBE_ALT, probe_v);
            @(posedge aclk);
            gen_peak = longint'(apogee);
            while (request_queue.size() < PHASE_ITEMS) begin
                if ($urandom_range(0, 4) != 0) add_flight();
                else add_noise();
            end
            wait_idle();
        end

        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
